[rtl/pswl_pkg.sv]
// Package for the per-source sliding window limiter.
// Holds opcodes, status codes, the transaction structs and the controller types.
// No dependencies.
package pswl_pkg;

  localparam logic [1:0] OP_ADMIT    = 2'd0;
  localparam logic [1:0] OP_ROLLBACK = 2'd1;
  localparam logic [1:0] OP_OVERRIDE = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  localparam logic [1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [1:0] STAT_PRIVACY  = 2'd1;
  localparam logic [1:0] STAT_OVER     = 2'd2;
  localparam logic [1:0] STAT_DONE     = 2'd3;

  // Ten minutes in milliseconds.
  localparam logic [31:0] SLOT_MS = 32'd600000;
  // (2^32 - 1) / SLOT_MS fits in 13 bits.
  localparam int QUOT_W = 13;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  source_index;
    logic [31:0] now_ms;
    logic [1:0]  event_privacy;
    logic [7:0]  default_ceiling;
    logic [7:0]  override_value;
  } pswl_in_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  status;
    logic [15:0] window_total;
  } pswl_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_ROT,
    S_SUM,
    S_COMMIT,
    S_EMIT
  } pswl_state_t;

  typedef struct packed {
    logic take;
    logic load;
    logic div_start;
    logic rotate;
    logic step;
    logic commit;
    logic emit;
  } pswl_cmd_t;

  typedef struct packed {
    logic quick;
    logic admit;
    logic div_done;
    logic sum_last;
  } pswl_sts_t;

endpackage

[rtl/pswl_div.sv]
// Divider of elapsed time by the slot length, by reciprocal multiplication.
// Depends on pswl_pkg for SLOT_MS and QUOT_W.
module pswl_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [31:0]                  dividend,
  output logic                         done,
  output logic [pswl_pkg::QUOT_W-1:0]  quot,
  output logic [31:0]                  rem
);
  import pswl_pkg::*;

  // SLOT_MS is 9375 * 64. The low six bits are dropped first, and the 26-bit rest is
  // divided by 9375 as its product with ceil(2^40 / 9375), shifted right by 40.
  // That product error stays below one unit for every 26-bit value.
  localparam int               PRE_SH = 6;
  localparam int               DVD_W  = 32 - PRE_SH;
  localparam int               RCP_W  = 27;
  localparam int               PROD_W = DVD_W + RCP_W;
  localparam int               RCP_SH = 40;
  localparam logic [RCP_W-1:0] RECIP  = 27'd117281241;

  logic              busy_r;
  logic              phase_r;
  logic [31:0]       dvd_r;
  logic [QUOT_W-1:0] quot_r;
  logic [31:0]       rem_r;
  logic [PROD_W-1:0] prod;
  logic [31:0]       back;

  assign prod = PROD_W'(dvd_r[31:PRE_SH]) * PROD_W'(RECIP);
  // The quotient is at most 7158, so quotient times SLOT_MS fits in 32 bits.
  assign back = 32'(quot_r) * SLOT_MS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
    end else if (start) begin
      busy_r  <= 1'b1;
      phase_r <= 1'b0;
    end else if (busy_r) begin
      if (!phase_r) begin
        phase_r <= 1'b1;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
    end else if (busy_r) begin
      if (!phase_r) begin
        quot_r <= prod[RCP_SH +: QUOT_W];
      end else begin
        rem_r <= dvd_r - back;
      end
    end
  end

  assign done = ~busy_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

[rtl/pswl_dp.sv]
// Datapath of the limiter: per-source row memory, active bits, slot rotation,
// window summing, ceiling checks and the result register.
// Depends on pswl_pkg and pswl_div.
module pswl_dp #(
  parameter int SOURCES = 16,
  parameter int SLOTS   = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pswl_pkg::pswl_in_t   in_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  input  pswl_pkg::pswl_cmd_t  cmd,
  output pswl_pkg::pswl_sts_t  sts,
  output pswl_pkg::pswl_out_t  out_data
);
  import pswl_pkg::*;

  localparam int IW    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int BKT_W = SLOTS * 16;
  localparam int ROW_W = 8 + 32 + BKT_W;
  localparam int ACC_W = 16 + SW;

  // Row layout: override, anchor, buckets (oldest in the low bits).
  logic [ROW_W-1:0]   mem [SOURCES];
  logic [ROW_W-1:0]   rd_r;
  logic [SOURCES-1:0] active_r;
  logic [1:0]         ceil_r;
  pswl_in_t           item_r;
  logic [BKT_W-1:0]   row_r;
  logic [BKT_W-1:0]   scan_r;
  logic [31:0]        anchor_r;
  logic [7:0]         ovr_r;
  logic [ACC_W-1:0]   acc_r;
  logic [SW-1:0]      cnt_r;
  pswl_out_t          res_r;
  pswl_out_t          out_r;

  logic [IW+3:0]      in_src_w;
  logic [IW+3:0]      item_src_w;
  logic [IW-1:0]      in_addr;
  logic [IW-1:0]      item_addr;
  logic               in_src_ok;
  logic               src_ok;
  logic               item_active;

  logic [7:0]         rd_ovr;
  logic [31:0]        rd_anchor;
  logic [BKT_W-1:0]   rd_bkt;
  logic [BKT_W-1:0]   load_bkt;
  logic [31:0]        load_anchor;
  logic [7:0]         load_ovr;

  logic               quick;
  logic [1:0]         quick_stat;

  logic [QUOT_W-1:0]  quot;
  logic [31:0]        rem;
  logic               div_done;
  logic               q_big;
  logic [SW-1:0]      q_small;
  logic [BKT_W-1:0]   rot_bkt;

  logic [15:0]        total;
  logic [7:0]         eff_ceil;
  logic               over;
  logic [15:0]        newest;
  logic [BKT_W-1:0]   new_row;
  logic [7:0]         new_ovr;
  pswl_out_t          commit_res;

  assign in_src_w   = (IW + 4)'(in_data.source_index);
  assign item_src_w = (IW + 4)'(item_r.source_index);
  assign in_addr    = in_src_w[IW-1:0];
  assign item_addr  = item_src_w[IW-1:0];
  assign in_src_ok  = ({28'd0, in_data.source_index} < 32'(SOURCES));
  assign src_ok     = ({28'd0, item_r.source_index} < 32'(SOURCES));
  assign item_active = src_ok ? active_r[item_addr] : 1'b0;

  assign rd_ovr    = rd_r[ROW_W-1 -: 8];
  assign rd_anchor = rd_r[BKT_W +: 32];
  assign rd_bkt    = rd_r[BKT_W-1:0];

  // A source seen for the first time starts with empty buckets at the item's time.
  assign load_bkt    = item_active ? rd_bkt : '0;
  assign load_anchor = item_active ? rd_anchor : item_r.now_ms;
  assign load_ovr    = item_active ? rd_ovr : 8'd0;

  always_comb begin
    quick      = 1'b0;
    quick_stat = STAT_DONE;
    case (item_r.opcode)
      OP_ADMIT: begin
        if (item_r.event_privacy > ceil_r) begin
          quick      = 1'b1;
          quick_stat = STAT_PRIVACY;
        end else if (!src_ok) begin
          quick      = 1'b1;
          quick_stat = STAT_OVER;
        end
      end
      OP_ROLLBACK: begin
        quick = ~item_active;
      end
      OP_OVERRIDE: begin
        quick = ~src_ok;
      end
      default: begin
        quick = 1'b1;
      end
    endcase
  end

  pswl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (item_r.now_ms - load_anchor),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  // Whole elapsed slots shift the buckets toward the oldest end.
  assign q_big   = (quot >= QUOT_W'(SLOTS));
  assign q_small = quot[SW-1:0];
  assign rot_bkt = q_big ? '0 : (row_r >> {q_small, 4'd0});

  assign total    = (acc_r > ACC_W'(COUNT_MAX)) ? COUNT_MAX : acc_r[15:0];
  assign eff_ceil = (ovr_r != 8'd0) ? ovr_r : item_r.default_ceiling;
  assign over     = (eff_ceil != 8'd0) && (total >= {8'd0, eff_ceil});
  assign newest   = row_r[BKT_W-1 -: 16];

  always_comb begin
    new_row = row_r;
    new_ovr = ovr_r;
    commit_res.accepted     = 1'b0;
    commit_res.status       = STAT_DONE;
    commit_res.window_total = total;
    case (item_r.opcode)
      OP_ADMIT: begin
        if (over) begin
          commit_res.status = STAT_OVER;
        end else begin
          commit_res.accepted = 1'b1;
          commit_res.status   = STAT_ACCEPTED;
          if (newest != COUNT_MAX) begin
            new_row[BKT_W-1 -: 16] = newest + 16'd1;
          end
        end
      end
      OP_ROLLBACK: begin
        if (newest != 16'd0) begin
          new_row[BKT_W-1 -: 16] = newest - 16'd1;
        end
      end
      OP_OVERRIDE: begin
        new_ovr = item_r.override_value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[item_addr] <= {new_ovr, anchor_r, new_row};
    end
    if (cmd.take && in_src_ok) begin
      rd_r <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      ceil_r   <= 2'd0;
    end else begin
      if (cfg_we) begin
        ceil_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        active_r[item_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_r <= in_data;
    end
    if (cmd.load) begin
      row_r    <= load_bkt;
      scan_r   <= load_bkt;
      anchor_r <= load_anchor;
      ovr_r    <= load_ovr;
      acc_r    <= '0;
      cnt_r    <= '0;
      if (quick) begin
        res_r.accepted     <= 1'b0;
        res_r.status       <= quick_stat;
        res_r.window_total <= 16'd0;
      end
    end
    if (cmd.rotate) begin
      row_r    <= rot_bkt;
      scan_r   <= rot_bkt;
      // anchor + n * SLOT_MS equals now minus the leftover part of a slot.
      anchor_r <= item_r.now_ms - rem;
      acc_r    <= '0;
      cnt_r    <= '0;
    end
    if (cmd.step) begin
      acc_r  <= acc_r + ACC_W'(scan_r[15:0]);
      scan_r <= scan_r >> 16;
      cnt_r  <= cnt_r + SW'(1);
    end
    if (cmd.commit) begin
      res_r <= commit_res;
    end
    if (cmd.emit) begin
      out_r <= res_r;
    end
  end

  assign sts.quick    = quick;
  assign sts.admit    = (item_r.opcode == OP_ADMIT);
  assign sts.div_done = div_done;
  assign sts.sum_last = (cnt_r == SW'(SLOTS - 1));
  assign out_data     = out_r;

endmodule

[rtl/pswl_ctrl.sv]
// Controller of the limiter: sequences load, division, rotation, summing,
// commit and result hand-off, and owns the input and output handshakes.
// Depends on pswl_pkg.
module pswl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pswl_pkg::pswl_sts_t  sts,
  output pswl_pkg::pswl_cmd_t  cmd
);
  import pswl_pkg::*;

  pswl_state_t state_r;
  pswl_state_t state_nxt;
  logic        out_valid_r;
  logic        out_free;

  assign out_free = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts.quick) begin
          state_nxt = S_EMIT;
        end else if (sts.admit) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_SUM;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (sts.sum_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // No transaction is taken while reset is held.
        in_ready = rst_n;
        cmd.take = in_valid & rst_n;
      end
      S_LOAD: begin
        cmd.load      = 1'b1;
        cmd.div_start = sts.admit & ~sts.quick;
      end
      S_DIV: begin
      end
      S_ROT: begin
        cmd.rotate = 1'b1;
      end
      S_SUM: begin
        cmd.step = 1'b1;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/per_source_sliding_window_limiter_unit.sv]
// One transaction at a time. Items decided without the row (privacy, bad source, unknown
// opcode, rollback of an unseen source) go from load to emit; rollback and set_override
// sum and commit in between; other admits also pass the slot divider and rotation first.
// A new item can be taken once the result is in the output register, which holds it while
// out_ready is low. Synchronous active-low reset clears the controller, the active bits
// and the privacy ceiling; rows are rebuilt on first use.
module per_source_sliding_window_limiter_unit #(
  parameter int SOURCES = 16,
  parameter int SLOTS   = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pswl_pkg::pswl_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pswl_pkg::pswl_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_wdata
);
  import pswl_pkg::*;

  pswl_cmd_t cmd;
  pswl_sts_t sts;

  // The ceiling register takes a write in any cycle outside reset.
  assign cfg_ready = rst_n;

  pswl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pswl_dp #(
    .SOURCES (SOURCES),
    .SLOTS   (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result register loaded while a result was pending");

  // Only one item is in flight.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one was in flight");

  a_accept_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.accepted == (out_data.status == STAT_ACCEPTED)))
    else $error("accepted flag disagrees with status");

  a_privacy_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STAT_PRIVACY) |-> (out_data.window_total == 16'd0))
    else $error("privacy rejection carried a window total");

endmodule
